@@ design/clti_pkg.sv @@
// shared types and constants for the clamped table interpolator
// widths, register indexes, range status codes and the item structs
// no dependencies
`timescale 1ns / 1ps

package clti_pkg;

  localparam int TABLE_DEPTH     = 1024;
  localparam int ADDR_WIDTH      = $clog2(TABLE_DEPTH);
  localparam int VALUE_WIDTH     = 32;
  localparam int TEMP_WIDTH      = 24;
  localparam int INV_STEP_WIDTH  = 24;
  localparam int MAX_INDEX_WIDTH = 10;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 24;

  // Q4.20 times Q12.12 gives 32 fraction bits
  localparam int POS_WIDTH      = TEMP_WIDTH + INV_STEP_WIDTH;
  localparam int POS_FRAC_BITS  = 32;
  localparam int IDX_WIDTH      = POS_WIDTH - POS_FRAC_BITS;
  localparam int FRAC_WIDTH     = 16;
  localparam int PROD_WIDTH     = VALUE_WIDTH + FRAC_WIDTH;
  localparam int SUM_WIDTH      = VALUE_WIDTH + 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_T_MIN     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_T_MAX     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_STEP  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_INDEX = 2'd3;

  localparam logic [TEMP_WIDTH-1:0]      T_MIN_RESET     = 24'd1572864;
  localparam logic [TEMP_WIDTH-1:0]      T_MAX_RESET     = 24'd2272264;
  localparam logic [INV_STEP_WIDTH-1:0]  INV_STEP_RESET  = 24'd4096000;
  localparam logic [MAX_INDEX_WIDTH-1:0] MAX_INDEX_RESET = 10'd667;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;
  localparam logic [1:0] ST_TOP    = 2'd3;

  typedef struct packed {
    logic                          kind;
    logic [ADDR_WIDTH-1:0]         table_addr;
    logic signed [VALUE_WIDTH-1:0] table_value;
    logic [TEMP_WIDTH-1:0]         temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    range_status;
  } out_item_t;

  // lookup bookkeeping that travels alongside the table read
  typedef struct packed {
    logic                  valid;
    logic [1:0]            status;
    logic [FRAC_WIDTH-1:0] frac;
  } lookup_tag_t;

  // table access issued by the front end, one per cycle while the pipeline advances
  typedef struct packed {
    logic                          we;
    logic [ADDR_WIDTH-1:0]         wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;
    logic [ADDR_WIDTH-1:0]         rd_addr_a;
    logic [ADDR_WIDTH-1:0]         rd_addr_b;
    lookup_tag_t                   tag;
  } table_req_t;

endpackage

@@ design/clti_front.sv @@
// front end: range compare, grid position multiply, cell and address select
// two register stages, then the table request as combinational output
// depends on clti_pkg
`timescale 1ns / 1ps

module clti_front import clti_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  in_item_t                   in_data,
  input  logic [TEMP_WIDTH-1:0]      t_min,
  input  logic [TEMP_WIDTH-1:0]      t_max,
  input  logic [INV_STEP_WIDTH-1:0]  inv_step,
  input  logic [MAX_INDEX_WIDTH-1:0] max_index,
  output table_req_t                 req
);

  // stage a: compares and offset from the grid start
  logic                          a_valid;
  logic                          a_kind;
  logic [ADDR_WIDTH-1:0]         a_addr;
  logic signed [VALUE_WIDTH-1:0] a_value;
  logic                          a_below;
  logic                          a_above;
  logic [TEMP_WIDTH-1:0]         a_diff;

  // stage b: exact grid position
  logic                          b_valid;
  logic                          b_kind;
  logic [ADDR_WIDTH-1:0]         b_addr;
  logic signed [VALUE_WIDTH-1:0] b_value;
  logic                          b_below;
  logic                          b_above;
  logic [POS_WIDTH-1:0]          b_pos;

  logic [IDX_WIDTH-1:0]  idx;
  logic [FRAC_WIDTH-1:0] frac;
  logic                  at_top;
  logic [1:0]            status;
  logic [ADDR_WIDTH-1:0] addr_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind  <= in_data.kind;
      a_addr  <= in_data.table_addr;
      a_value <= in_data.table_value;
      a_below <= in_data.temperature < t_min;
      a_above <= in_data.temperature > t_max;
      a_diff  <= in_data.temperature - t_min;

      b_kind  <= a_kind;
      b_addr  <= a_addr;
      b_value <= a_value;
      b_below <= a_below;
      b_above <= a_above;
      b_pos   <= POS_WIDTH'(a_diff) * POS_WIDTH'(inv_step);
    end
  end

  assign idx    = b_pos[POS_WIDTH-1:POS_FRAC_BITS];
  assign frac   = b_pos[POS_FRAC_BITS-1 -: FRAC_WIDTH];
  assign at_top = idx >= IDX_WIDTH'(max_index);

  // below minimum wins over all the other cases
  always_comb begin
    priority if (b_below) begin
      status = ST_BELOW;
      addr_a = '0;
    end else if (b_above) begin
      status = ST_ABOVE;
      addr_a = max_index[ADDR_WIDTH-1:0];
    end else if (at_top) begin
      status = ST_TOP;
      addr_a = max_index[ADDR_WIDTH-1:0];
    end else begin
      status = ST_INTERP;
      addr_a = idx[ADDR_WIDTH-1:0];
    end
  end

  assign req.we         = b_valid && (b_kind == KIND_WRITE);
  assign req.wr_addr    = b_addr;
  assign req.wr_data    = b_value;
  assign req.rd_addr_a  = addr_a;
  assign req.rd_addr_b  = addr_a + ADDR_WIDTH'(1);
  assign req.tag.valid  = b_valid && (b_kind == KIND_LOOKUP);
  assign req.tag.status = status;
  assign req.tag.frac   = frac;

  // an interpolating lookup always sits strictly below the last entry
  assert property (@(posedge clk) disable iff (rst)
    req.tag.valid && (status == ST_INTERP) |-> (idx < IDX_WIDTH'(max_index)))
    else $error("interpolation cell at or past the last entry");

  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(b_pos) && $stable(b_valid))
    else $error("position stage moved during a stall");

endmodule

@@ design/clti_table.sv @@
// property table: one write port and two registered read ports
// the lookup tag is registered alongside the read data
// depends on clti_pkg
`timescale 1ns / 1ps

module clti_table import clti_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  table_req_t                    req,
  output logic signed [VALUE_WIDTH-1:0] rd_a,
  output logic signed [VALUE_WIDTH-1:0] rd_b,
  output lookup_tag_t                   tag
);

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  // writes and reads sit in the same stage, so item order is kept
  always_ff @(posedge clk) begin
    if (adv) begin
      if (req.we) begin
        mem[req.wr_addr] <= req.wr_data;
      end
      rd_a <= mem[req.rd_addr_a];
      rd_b <= mem[req.rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag.status <= req.tag.status;
      tag.frac   <= req.tag.frac;
    end
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (adv) begin
      tag.valid <= req.tag.valid;
    end
  end

endmodule

@@ design/clti_blend.sv @@
// blend: slope magnitude, fraction multiply, signed add and saturation
// three register stages, the last one is the output register
// depends on clti_pkg
`timescale 1ns / 1ps

module clti_blend import clti_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic signed [VALUE_WIDTH-1:0] rd_a,
  input  logic signed [VALUE_WIDTH-1:0] rd_b,
  input  lookup_tag_t                   tag,
  output logic                          out_valid,
  output out_item_t                     out_data
);

  localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
    {{(SUM_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic signed [VALUE_WIDTH:0] diff;
  logic                        diff_neg;
  logic [VALUE_WIDTH:0]        diff_abs;

  logic                          d_valid;
  logic [1:0]                    d_status;
  logic [FRAC_WIDTH-1:0]         d_frac;
  logic signed [VALUE_WIDTH-1:0] d_a;
  logic                          d_neg;
  logic [VALUE_WIDTH-1:0]        d_mag;

  logic                          e_valid;
  logic [1:0]                    e_status;
  logic signed [VALUE_WIDTH-1:0] e_a;
  logic                          e_neg;
  logic [VALUE_WIDTH-1:0]        e_q;
  logic [PROD_WIDTH-1:0]         prod;

  logic signed [SUM_WIDTH-1:0] step;
  logic signed [SUM_WIDTH-1:0] sum;
  logic signed [VALUE_WIDTH-1:0] sat;
  logic signed [VALUE_WIDTH-1:0] result;

  assign diff     = {rd_b[VALUE_WIDTH-1], rd_b} - {rd_a[VALUE_WIDTH-1], rd_a};
  assign diff_neg = diff[VALUE_WIDTH];
  assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;

  // magnitude times fraction, floor of the top bits gives round toward zero
  assign prod = PROD_WIDTH'(d_mag) * PROD_WIDTH'(d_frac);

  assign step = e_neg ? -$signed({2'b00, e_q}) : $signed({2'b00, e_q});
  assign sum  = {{2{e_a[VALUE_WIDTH-1]}}, e_a} + step;

  always_comb begin
    priority if (sum > SAT_HI) begin
      sat = SAT_HI[VALUE_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      sat = SAT_LO[VALUE_WIDTH-1:0];
    end else begin
      sat = sum[VALUE_WIDTH-1:0];
    end
  end

  // clamped cases already read the right entry into a
  assign result = (e_status == ST_INTERP) ? sat : e_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      d_valid   <= tag.valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_status <= tag.status;
      d_frac   <= tag.frac;
      d_a      <= rd_a;
      d_neg    <= diff_neg;
      d_mag    <= diff_abs[VALUE_WIDTH-1:0];

      e_status <= d_status;
      e_a      <= d_a;
      e_neg    <= d_neg;
      e_q      <= prod[PROD_WIDTH-1:FRAC_WIDTH];

      out_data.value        <= result;
      out_data.range_status <= e_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    adv && d_valid |=> (e_q <= $past(d_mag)))
    else $error("scaled slope exceeds the full slope");

  assert property (@(posedge clk)
    rst |=> !out_valid && !d_valid && !e_valid)
    else $error("result pending after reset");

endmodule

@@ design/clamped_table_linear_interp.sv @@
// top level of the clamped table interpolator
// holds the configuration registers and joins front end, table and blend
// depends on clti_pkg, clti_front, clti_table, clti_blend
`timescale 1ns / 1ps

// Usage
//   in_valid/in_ready/in_data carry items: kind 0 writes table_value to
//   table_addr and gives no result, kind 1 looks up temperature.
//   out_valid/out_ready/out_data carry one result per lookup: the value
//   and its range status (interpolated, below, above, at top index).
//   cfg_we/cfg_index/cfg_data write t_min, t_max, inv_step and max_index;
//   write them only while no item is in flight.
// Timing
//   one item per cycle while the output is not held; a lookup result
//   passes six register stages after acceptance, the last being the
//   output register. The position and slope multiplies each take a stage,
//   and the table is read at two addresses in one registered stage.
//   Writes are applied in the table stage, in order with lookups.
// Reset and stall
//   rst (synchronous) empties the pipeline and loads the default grid;
//   table contents are not cleared and must be written before use.
//   When out_ready is low with a result waiting the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
module clamped_table_linear_interp import clti_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic [TEMP_WIDTH-1:0]      t_min;
  logic [TEMP_WIDTH-1:0]      t_max;
  logic [INV_STEP_WIDTH-1:0]  inv_step;
  logic [MAX_INDEX_WIDTH-1:0] max_index;

  logic                          adv;
  table_req_t                    req;
  logic signed [VALUE_WIDTH-1:0] rd_a;
  logic signed [VALUE_WIDTH-1:0] rd_b;
  lookup_tag_t                   tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_min     <= T_MIN_RESET;
      t_max     <= T_MAX_RESET;
      inv_step  <= INV_STEP_RESET;
      max_index <= MAX_INDEX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_T_MIN:     t_min     <= cfg_data[TEMP_WIDTH-1:0];
        CFG_T_MAX:     t_max     <= cfg_data[TEMP_WIDTH-1:0];
        CFG_INV_STEP:  inv_step  <= cfg_data[INV_STEP_WIDTH-1:0];
        CFG_MAX_INDEX: max_index <= cfg_data[MAX_INDEX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves together unless a result is held at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  clti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .t_min     (t_min),
    .t_max     (t_max),
    .inv_step  (inv_step),
    .max_index (max_index),
    .req       (req)
  );

  clti_table u_table (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b),
    .tag  (tag)
  );

  clti_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .tag       (tag),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ verif/clti_checker.sv @@
// result checker for the clamped table interpolator: keeps its own table and grid,
// predicts each lookup in order of acceptance and compares the results field by field
// depends on clti_pkg
`timescale 1ns / 1ps

module clti_checker import clti_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  in_item_t                   in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  out_item_t                  out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                         fail_count,
  output int                         outstanding
);

  localparam longint WORD_HI = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint WORD_LO = -WORD_HI - 1;

  logic signed [VALUE_WIDTH-1:0] prop_table [TABLE_DEPTH];
  logic [TEMP_WIDTH-1:0]         grid_t_min;
  logic [TEMP_WIDTH-1:0]         grid_t_max;
  logic [INV_STEP_WIDTH-1:0]     grid_inv_step;
  logic [MAX_INDEX_WIDTH-1:0]    grid_max_index;
  out_item_t                     lookup_q [$];
  out_item_t                     want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic out_item_t interpolate(input logic [TEMP_WIDTH-1:0] temp);
    logic [POS_WIDTH-1:0]  dt;
    logic [POS_WIDTH-1:0]  pos;
    logic [IDX_WIDTH-1:0]  pos_idx;
    logic [FRAC_WIDTH-1:0] frac;
    longint                weight;
    longint                lo_val;
    longint                hi_val;
    longint                diff;
    longint                mag;
    longint                step;
    longint                sum;
    out_item_t             r;
    if (temp < grid_t_min) begin
      r.value        = prop_table[0];
      r.range_status = ST_BELOW;
    end else if (temp > grid_t_max) begin
      r.value        = prop_table[grid_max_index];
      r.range_status = ST_ABOVE;
    end else begin
      dt      = POS_WIDTH'(temp) - POS_WIDTH'(grid_t_min);
      pos     = dt * POS_WIDTH'(grid_inv_step);
      pos_idx = pos[POS_WIDTH-1 -: IDX_WIDTH];
      frac    = pos[POS_FRAC_BITS-1 -: FRAC_WIDTH];
      if (pos_idx >= IDX_WIDTH'(grid_max_index)) begin
        r.value        = prop_table[grid_max_index];
        r.range_status = ST_TOP;
      end else begin
        weight = longint'(frac);
        lo_val = longint'(prop_table[pos_idx[ADDR_WIDTH-1:0]]);
        hi_val = longint'(prop_table[pos_idx[ADDR_WIDTH-1:0] + ADDR_WIDTH'(1)]);
        diff   = hi_val - lo_val;
        mag    = (diff < 0) ? -diff : diff;
        // magnitude scaled and truncated, so the step rounds toward zero
        step   = (mag * weight) >> FRAC_WIDTH;
        if (diff < 0) step = -step;
        sum = lo_val + step;
        if (sum > WORD_HI) sum = WORD_HI;
        else if (sum < WORD_LO) sum = WORD_LO;
        r.value        = sum[VALUE_WIDTH-1:0];
        r.range_status = ST_INTERP;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_t_min     = T_MIN_RESET;
      grid_t_max     = T_MAX_RESET;
      grid_inv_step  = INV_STEP_RESET;
      grid_max_index = MAX_INDEX_RESET;
      lookup_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: value %0d status %0d", $time,
                   out_data.value, out_data.range_status);
        end else begin
          want = lookup_q.pop_front();
          if (out_data.value !== want.value) begin
            fail_count++;
            $display("%0t value mismatch: expected %0d, got %0d", $time,
                     want.value, out_data.value);
          end
          if (out_data.range_status !== want.range_status) begin
            fail_count++;
            $display("%0t range status mismatch: expected %0d, got %0d", $time,
                     want.range_status, out_data.range_status);
          end
        end
      end
      // items are applied in order, so a write is seen by every later lookup
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_WRITE) prop_table[in_data.table_addr] = in_data.table_value;
        else lookup_q.push_back(interpolate(in_data.temperature));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_T_MIN:     grid_t_min     = cfg_data[TEMP_WIDTH-1:0];
          CFG_T_MAX:     grid_t_max     = cfg_data[TEMP_WIDTH-1:0];
          CFG_INV_STEP:  grid_inv_step  = cfg_data[INV_STEP_WIDTH-1:0];
          CFG_MAX_INDEX: grid_max_index = cfg_data[MAX_INDEX_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    outstanding = lookup_q.size();
  end

endmodule

@@ verif/testbench.sv @@
// top of the clamped table interpolator testbench: clock, reset, item stimulus,
// grid settings and the verdict; checking is done by clti_checker
// depends on clti_pkg, clti_checker and clamped_table_linear_interp
`timescale 1ns / 1ps

module testbench;
  import clti_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     DRAIN_CYCLES   = 10;
  localparam longint TEMP_TOP       = (longint'(1) << TEMP_WIDTH) - 1;
  localparam logic signed [VALUE_WIDTH-1:0] WORD_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] WORD_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_item_t                   in_data;
  logic                       out_valid;
  logic                       out_ready;
  out_item_t                  out_data;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data;
  int                         fail_count;
  int                         outstanding;
  int                         quiet_cycles = 0;
  bit                         calm;

  // the grid as last written, used to aim temperatures
  logic [TEMP_WIDTH-1:0]      aim_t_min;
  logic [TEMP_WIDTH-1:0]      aim_t_max;
  logic [INV_STEP_WIDTH-1:0]  aim_inv_step;
  logic [MAX_INDEX_WIDTH-1:0] aim_max_index;

  always #4 clk = ~clk;

  clamped_table_linear_interp dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clti_checker lookup_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL clamped_table_linear_interp");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] pick_word();
    case ($urandom_range(7))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return $signed($urandom_range(2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TEMP_WIDTH-1:0] pick_temp();
    longint lo;
    longint hi;
    longint span;
    longint t;
    int     r;
    lo   = longint'(aim_t_min);
    hi   = longint'(aim_t_max);
    span = (aim_inv_step == 0) ? TEMP_TOP + 1 :
           (longint'(aim_max_index) << POS_FRAC_BITS) / longint'(aim_inv_step);
    // top of the part of the grid that interpolates
    if (lo + span < hi) hi = lo + span;
    r = $urandom_range(99);
    if (r < 10) t = lo - 1 - $urandom_range(3000);
    else if (r < 20) t = longint'(aim_t_max) + 1 + $urandom_range(3000);
    else if (r < 25) t = $urandom_range(1) ? longint'(aim_t_min) : longint'(aim_t_max);
    else if (r < 35) t = $urandom_range(TEMP_TOP);
    else if (r < 45) t = hi + $urandom_range(4000) - 2000;
    else if (lo <= hi) t = lo + $urandom_range(hi - lo);
    else t = $urandom_range(TEMP_TOP);
    if (t < 0) t = 0;
    if (t > TEMP_TOP) t = TEMP_TOP;
    return t[TEMP_WIDTH-1:0];
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(input in_item_t it);
    int gap;
    gap = (!calm && $urandom_range(99) < 20) ? $urandom_range(2, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic store(input int addr, input logic signed [VALUE_WIDTH-1:0] word);
    in_item_t it;
    it.kind        = KIND_WRITE;
    it.table_addr  = ADDR_WIDTH'(addr);
    it.table_value = word;
    it.temperature = TEMP_WIDTH'($urandom);
    push_item(it);
  endtask

  task automatic lookup(input logic [TEMP_WIDTH-1:0] temp);
    in_item_t it;
    it.kind        = KIND_LOOKUP;
    it.table_addr  = ADDR_WIDTH'($urandom);
    it.table_value = $urandom;
    it.temperature = temp;
    push_item(it);
  endtask

  task automatic run_mix(input int count);
    repeat (count) begin
      if ($urandom_range(99) < 20) store($urandom_range(TABLE_DEPTH - 1), pick_word());
      else lookup(pick_temp());
    end
  endtask

  // stop sending and let every lookup and any trailing write leave the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic write_grid(input logic [TEMP_WIDTH-1:0] lo, input logic [TEMP_WIDTH-1:0] hi,
                            input logic [INV_STEP_WIDTH-1:0] inv,
                            input logic [MAX_INDEX_WIDTH-1:0] top);
    wait_drained();
    aim_t_min     = lo;
    aim_t_max     = hi;
    aim_inv_step  = inv;
    aim_max_index = top;
    cfg_write(CFG_T_MIN, lo);
    cfg_write(CFG_T_MAX, hi);
    cfg_write(CFG_INV_STEP, inv);
    cfg_write(CFG_MAX_INDEX, CFG_DATA_WIDTH'(top));
    cfg_we <= 1'b0;
  endtask

  task automatic random_grid();
    longint top;
    longint inv;
    longint span;
    longint lo;
    longint hi;
    case ($urandom_range(5))
      0:       top = 1;
      1:       top = TABLE_DEPTH - 1;
      default: top = $urandom_range(TABLE_DEPTH - 1, 1);
    endcase
    case ($urandom_range(5))
      0:       inv = 1;
      1:       inv = TEMP_TOP;
      default: inv = $urandom_range(TEMP_TOP, 1) >> $urandom_range(20);
    endcase
    if (inv == 0) inv = 1;
    span = (top << POS_FRAC_BITS) / inv;
    if (span > TEMP_TOP) span = TEMP_TOP;
    lo = $urandom_range(TEMP_TOP - span);
    // t_max lands a little short of or past the top cell
    hi = lo + span * $urandom_range(120, 70) / 100;
    if (hi > TEMP_TOP) hi = TEMP_TOP;
    write_grid(TEMP_WIDTH'(lo), TEMP_WIDTH'(hi), INV_STEP_WIDTH'(inv),
               MAX_INDEX_WIDTH'(top));
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    aim_t_min     = T_MIN_RESET;
    aim_t_max     = T_MAX_RESET;
    aim_inv_step  = INV_STEP_RESET;
    aim_max_index = MAX_INDEX_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every entry is written before any lookup can read it
    for (int a = 0; a < TABLE_DEPTH; a++) store(a, pick_word());

    // default grid: bounds, neighbours at opposite extremes, write then read
    store(0, -5);
    store(1, WORD_MAX);
    store(2, WORD_MIN);
    store(3, WORD_MAX);
    store(4, 0);
    store(TABLE_DEPTH - 1, WORD_MIN);
    lookup('0);
    lookup(TEMP_WIDTH'(T_MIN_RESET - 1));
    lookup(T_MIN_RESET);
    lookup(TEMP_WIDTH'(T_MIN_RESET + 1573));
    lookup(TEMP_WIDTH'(T_MIN_RESET + 2621));
    lookup(TEMP_WIDTH'(T_MIN_RESET + 3145));
    lookup(T_MAX_RESET);
    lookup(TEMP_WIDTH'(T_MAX_RESET + 1));
    lookup('1);
    store(0, 123);
    lookup('0);

    // widest grid with the steepest step: nearly everything hits the top index
    write_grid('0, '1, '1, MAX_INDEX_WIDTH'(TABLE_DEPTH - 1));
    lookup('0);
    lookup('1);
    run_mix(8);

    // shallowest step and a two-entry table
    write_grid('0, '1, INV_STEP_WIDTH'(1), MAX_INDEX_WIDTH'(1));
    lookup('1);
    run_mix(8);

    // inverted bounds: the below-minimum test wins
    write_grid('1, '0, '0, '0);
    lookup(TEMP_WIDTH'(TEMP_TOP - 1));
    lookup('1);
    lookup('0);

    // zero step keeps the position at entry 0
    write_grid(24'h100000, 24'hf00000, '0, MAX_INDEX_WIDTH'(5));
    lookup(24'h100000);
    lookup(24'h800000);
    run_mix(4);

    // single-entry table: every in-range lookup is at the top index
    write_grid(24'h100000, 24'hf00000, INV_STEP_RESET, '0);
    lookup(24'h200000);
    run_mix(4);

    write_grid(T_MIN_RESET, T_MAX_RESET, INV_STEP_RESET, MAX_INDEX_RESET);
    run_mix(20);

    for (int g = 0; g < 4; g++) begin
      random_grid();
      calm = (g == 1);
      if (g == 1) begin
        run_mix(30);
      end else if (g == 2) begin
        run_mix(8);
        wait_drained();
        run_mix(8);
      end else begin
        run_mix(10);
      end
      calm = 1'b0;
    end

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS clamped_table_linear_interp");
    end else begin
      $display("FAIL clamped_table_linear_interp");
    end
    $finish;
  end

endmodule
